>>> hw/rtl/swrr_pkg.sv
// ----------------------------------------------------------------------------
// swrr_pkg: shared types and constants for the sound wave ring renderer
// Ring geometry, delay line sizing, brightness curve and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package swrr_pkg;

  // ring and delay line geometry
  localparam int LED_COUNT       = 16;
  localparam int DEGREES_PER_TAP = 20;
  localparam int LED_ZERO_OFFSET = 0;

  localparam int MAX_EMIT   = 16;
  localparam int EMIT_COUNT = (LED_COUNT < MAX_EMIT) ? LED_COUNT : MAX_EMIT;

  localparam int HALF_TURN = 180;
  localparam int FULL_TURN = 360;
  localparam int EAR_RIGHT = 80;
  localparam int EAR_LEFT  = FULL_TURN - 80;
  localparam int EAR_REACH = 100;

  localparam int HIST_DEPTH = HALF_TURN / DEGREES_PER_TAP + 1;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  // field widths
  localparam int IDX_W  = 4;
  localparam int AMP_W  = 8;
  localparam int GAIN_W = 8;
  localparam int LVL_W  = 8;
  localparam int DIST_W = 7;
  localparam int DX_W   = 7;
  localparam int MAG_W  = AMP_W + DX_W;

  // reciprocal for the divide by DEGREES_PER_TAP, exact for any MAG_W operand
  localparam int DIV_SHIFT = 23;
  localparam int DIV_RECIP = ((1 << DIV_SHIFT) + DEGREES_PER_TAP - 1) / DEGREES_PER_TAP;
  localparam int RECIP_W   = $clog2(DIV_RECIP + 1);

  // item codes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // register file
  localparam int   PADDR_W       = 3;
  localparam int   PDATA_W       = 32;
  localparam logic REG_WAVE_GAIN = 1'b0;

  // brightness curve
  localparam int CURVE_LEN = 17;
  localparam int CURVE_AW  = $clog2(CURVE_LEN);
  localparam logic [LVL_W-1:0] CURVE_POINTS [CURVE_LEN] = '{
    8'd0, 8'd3, 8'd7, 8'd12, 8'd18, 8'd25, 8'd33, 8'd43, 8'd55,
    8'd69, 8'd85, 8'd103, 8'd123, 8'd145, 8'd189, 8'd217, 8'd255
  };

  // per led geometry
  typedef struct packed {
    logic               hit;
    logic [DIST_W-1:0]  span;
    logic [HIST_AW-1:0] tap;
    logic [DX_W-1:0]    dx;
  } geom_t;

  typedef geom_t [MAX_EMIT-1:0] geom_table_t;

  // controller to datapath
  typedef struct packed {
    logic             issue;
    logic             push;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic [AMP_W-1:0] amplitude;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic advance;
  } dp_status_t;

  // wrapped distance between two angles already in 0..359
  function automatic int ring_dist(int x, int y);
    int d;
    d = (y >= x) ? (y - x) : (x - y);
    if (d >= HALF_TURN) d = FULL_TURN - d;
    return d;
  endfunction

  // turn direction from x towards y
  function automatic logic ring_pos(int x, int y);
    logic p;
    if (y >= x) p = ((y - x) < HALF_TURN);
    else p = ((x - y) >= HALF_TURN);
    return p;
  endfunction

  // geometry of every emitted led, worked out at elaboration
  function automatic geom_table_t build_geom();
    geom_table_t t;
    int          deg;
    int          d1;
    int          d2;
    int          span;
    logic        h1;
    logic        h2;
    t = '0;
    for (int i = 0; i < MAX_EMIT; i++) begin
      if (i < EMIT_COUNT) begin
        deg = (i * FULL_TURN) / LED_COUNT - LED_ZERO_OFFSET;
        if (deg < 0) deg = deg + FULL_TURN;
        d1 = ring_dist(deg, EAR_RIGHT);
        d2 = ring_dist(deg, EAR_LEFT);
        h1 = (d1 <= EAR_REACH) && !ring_pos(deg, EAR_RIGHT);
        h2 = (d2 <= EAR_REACH) && ring_pos(deg, EAR_LEFT);
        span = h2 ? d2 : (h1 ? d1 : 0);
        t[i].hit  = h1 || h2;
        t[i].span = DIST_W'(span);
        t[i].tap  = HIST_AW'(span / DEGREES_PER_TAP);
        t[i].dx   = DX_W'(span - (span / DEGREES_PER_TAP) * DEGREES_PER_TAP);
      end
    end
    return t;
  endfunction

  localparam geom_table_t GEOM_TABLE = build_geom();

endpackage

>>> hw/rtl/sound_wave_ring_renderer.sv
// Render: the input takes the request and then stalls, with one led issue per
// cycle while the pipeline advances, until the last emitted led is issued.
// Sample: the controller stays idle, so the next item is taken in the following cycle.
// Output stalls freeze the six-stage led pipeline and with it the led issue.
// Synchronous active-high reset clears the delay line valid bits, write
// pointer, controller state, pipeline valids and wave_gain.
// ----------------------------------------------------------------------------
// sound_wave_ring_renderer: top level
// Joins the item controller, the brightness datapath and the register port.
// ----------------------------------------------------------------------------
module sound_wave_ring_renderer
  import swrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [AMP_W-1:0]   amplitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   led_index,
  output logic [LVL_W-1:0]   brightness,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [GAIN_W-1:0] wave_gain;
  logic              reg_hit;

  // register port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_WAVE_GAIN);
  assign prdata  = reg_hit ? PDATA_W'(wave_gain) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_gain <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      wave_gain <= pwdata[GAIN_W-1:0];
    end
  end

  swrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .amplitude (amplitude),
    .status    (status),
    .cmd       (cmd)
  );

  swrr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .gain       (wave_gain),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .led_index  (led_index),
    .brightness (brightness),
    .last       (last)
  );

endmodule

>>> hw/rtl/swrr_ram.sv
// ----------------------------------------------------------------------------
// swrr_ram: generic ram
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module swrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> hw/rtl/swrr_ctrl.sv
// ----------------------------------------------------------------------------
// swrr_ctrl: item controller
// Takes input items, turns a sample into a delay line push and a render
// into one led issue per cycle while the datapath advances.
// ----------------------------------------------------------------------------
module swrr_ctrl
  import swrr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [AMP_W-1:0] amplitude,
  input  dp_status_t       status,
  output ctrl_cmd_t        cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_RENDER = 1'b1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EMIT_COUNT - 1);

  logic [0:0]       state;
  logic [0:0]       state_next;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_next;
  logic             accept;

  assign in_stall = (state == ST_RENDER);
  assign accept   = in_valid && (state == ST_IDLE);

  // commands to the datapath
  always_comb begin
    cmd.push      = accept && (operation == OP_PUSH);
    cmd.amplitude = amplitude;
    cmd.issue     = (state == ST_RENDER) && status.advance;
    cmd.idx       = cnt;
    cmd.last      = (cnt == LAST_IDX);
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept && (operation == OP_RENDER)) begin
          state_next = ST_RENDER;
          cnt_next   = '0;
        end
      end
      ST_RENDER: begin
        if (cmd.issue) begin
          if (cmd.last) begin
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // a render transfer starts the frame at the first led
  a_render_start: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_RENDER) |=> (state == ST_RENDER) && (cnt == '0))
    else $error("render did not start at the first led");

  // the final led hands control back
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && cmd.last |=> (state == ST_IDLE))
    else $error("frame did not end after the final led");

  // leds are issued only while the pipeline moves
  a_issue_adv: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> status.advance)
    else $error("led issued into a stalled pipeline");

endmodule

>>> hw/rtl/swrr_datapath.sv
// ----------------------------------------------------------------------------
// swrr_datapath: delay line and per-led brightness pipeline
// Circular delay line in ram, interpolation, gain, distance falloff,
// saturation and brightness curve over six pipeline stages.
// ----------------------------------------------------------------------------
module swrr_datapath
  import swrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  input  logic [GAIN_W-1:0] gain,
  output dp_status_t        status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  led_index,
  output logic [LVL_W-1:0]  brightness,
  output logic              last
);

  localparam logic [HIST_AW:0]   DEPTH_X   = (HIST_AW + 1)'(HIST_DEPTH);
  localparam logic [HIST_AW:0]   DEPTH_M1X = (HIST_AW + 1)'(HIST_DEPTH - 1);
  localparam logic [HIST_AW-1:0] DEPTH_M1  = HIST_AW'(HIST_DEPTH - 1);
  localparam int                 QP_W      = MAG_W + RECIP_W;

  logic advance;

  // delay line write side
  logic [HIST_AW-1:0]    wp;
  logic [HIST_DEPTH-1:0] hist_vld;

  // read address generation
  geom_t              geom;
  logic [HIST_AW:0]   sum;
  logic [HIST_AW-1:0] ra_lo;
  logic [HIST_AW-1:0] ra_hi;
  logic [AMP_W-1:0]   rd_lo;
  logic [AMP_W-1:0]   rd_hi;

  // stage 1
  logic              v1;
  logic [IDX_W-1:0]  idx1;
  logic              last1;
  logic              hit1;
  logic [DIST_W-1:0] dist1;
  logic [DX_W-1:0]   dx1;
  logic              vlo1;
  logic              vhi1;
  logic [AMP_W-1:0]  a1;
  logic [AMP_W-1:0]  b1;
  logic [AMP_W:0]    diff1;
  logic [AMP_W:0]    diff1_neg;
  logic [AMP_W-1:0]  absd1;
  logic [MAG_W-1:0]  mag1;

  // stage 2
  logic              v2;
  logic [IDX_W-1:0]  idx2;
  logic              last2;
  logic              hit2;
  logic [DIST_W-1:0] dist2;
  logic [AMP_W-1:0]  a2;
  logic              neg2;
  logic [MAG_W-1:0]  mag2;
  logic [QP_W-1:0]   qprod2;

  // stage 3
  logic              v3;
  logic [IDX_W-1:0]  idx3;
  logic              last3;
  logic              hit3;
  logic [DIST_W-1:0] dist3;
  logic [AMP_W-1:0]  a3;
  logic              neg3;
  logic [MAG_W-1:0]  q3;
  logic [AMP_W-1:0]  delta3;
  logic [AMP_W-1:0]  samp3;
  logic [AMP_W+GAIN_W-1:0] gprod3;

  // stage 4
  logic              v4;
  logic [IDX_W-1:0]  idx4;
  logic              last4;
  logic              hit4;
  logic [DIST_W-1:0] dist4;
  logic [AMP_W+GAIN_W-5:0] w4;
  logic [7:0]        weight4;
  logic [AMP_W+GAIN_W+3:0] fprod4;
  logic [AMP_W+GAIN_W-4:0] f4;
  logic [LVL_W-1:0]  lvl4;

  // stage 5
  logic              v5;
  logic [IDX_W-1:0]  idx5;
  logic              last5;
  logic [LVL_W-1:0]  lvl5;
  logic [CURVE_AW-1:0] cp5;
  logic [LVL_W-1:0]  clo5;
  logic [LVL_W-1:0]  chi5;
  logic [LVL_W-1:0]  cstep5;
  logic [LVL_W+3:0]  cprod5;
  logic [LVL_W-1:0]  bright5;

  // the whole pipeline moves unless the result register is held
  assign advance        = !(out_valid && out_stall);
  assign status.advance = advance;

  // delay line push: newest sample goes to the write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      hist_vld <= '0;
    end else if (cmd.push) begin
      hist_vld[wp] <= 1'b1;
      wp           <= (wp == DEPTH_M1) ? '0 : wp + HIST_AW'(1);
    end
  end

  // tap k lives at (wp - 1 - k) modulo the depth
  always_comb begin
    geom  = GEOM_TABLE[cmd.idx];
    sum   = {1'b0, wp} + DEPTH_M1X - {1'b0, geom.tap};
    ra_lo = (sum >= DEPTH_X) ? HIST_AW'(sum - DEPTH_X) : sum[HIST_AW-1:0];
    ra_hi = (ra_lo == '0) ? DEPTH_M1 : ra_lo - HIST_AW'(1);
  end

  swrr_ram #(
    .WIDTH (AMP_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk     (clk),
    .we      (cmd.push),
    .waddr   (wp),
    .wdata   (cmd.amplitude),
    .re      (cmd.issue),
    .raddr_a (ra_lo),
    .raddr_b (ra_hi),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= cmd.issue;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  // stage 1: neighbor difference times the fraction
  always_comb begin
    a1        = vlo1 ? rd_lo : '0;
    b1        = vhi1 ? rd_hi : '0;
    diff1     = {1'b0, b1} - {1'b0, a1};
    diff1_neg = '0 - diff1;
    absd1     = diff1[AMP_W] ? diff1_neg[AMP_W-1:0] : diff1[AMP_W-1:0];
    mag1      = absd1 * dx1;
  end

  // stage 2: divide by the tap spacing through the reciprocal
  assign qprod2 = QP_W'(mag2) * QP_W'(DIV_RECIP);

  // stage 3: interpolated sample, then gain
  always_comb begin
    delta3 = neg3 ? AMP_W'('0 - q3) : q3[AMP_W-1:0];
    samp3  = a3 + delta3;
    gprod3 = samp3 * gain;
  end

  // stage 4: distance falloff and saturation
  always_comb begin
    weight4 = 8'(HALF_TURN) - {1'b0, dist4};
    fprod4  = w4 * weight4;
    f4      = fprod4[AMP_W+GAIN_W+3:7];
    if (!hit4) begin
      lvl4 = '0;
    end else if (f4 > (AMP_W+GAIN_W-3)'(255)) begin
      lvl4 = 8'd255;
    end else begin
      lvl4 = f4[LVL_W-1:0];
    end
  end

  // stage 5: brightness curve
  always_comb begin
    cp5     = {1'b0, lvl5[7:4]};
    clo5    = CURVE_POINTS[cp5];
    chi5    = CURVE_POINTS[cp5 + CURVE_AW'(1)];
    cstep5  = chi5 - clo5;
    cprod5  = lvl5[3:0] * cstep5;
    bright5 = clo5 + cprod5[LVL_W+3:4];
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      idx1  <= cmd.idx;
      last1 <= cmd.last;
      hit1  <= geom.hit;
      dist1 <= geom.span;
      dx1   <= geom.dx;
      vlo1  <= hist_vld[ra_lo];
      vhi1  <= hist_vld[ra_hi];

      idx2  <= idx1;
      last2 <= last1;
      hit2  <= hit1;
      dist2 <= dist1;
      a2    <= a1;
      neg2  <= diff1[AMP_W];
      mag2  <= mag1;

      idx3  <= idx2;
      last3 <= last2;
      hit3  <= hit2;
      dist3 <= dist2;
      a3    <= a2;
      neg3  <= neg2;
      q3    <= MAG_W'(qprod2 >> DIV_SHIFT);

      idx4  <= idx3;
      last4 <= last3;
      hit4  <= hit3;
      dist4 <= dist3;
      w4    <= gprod3[AMP_W+GAIN_W-1:4];

      idx5  <= idx4;
      last5 <= last4;
      lvl5  <= lvl4;

      led_index  <= idx5;
      brightness <= bright5;
      last       <= last5;
    end
  end

  // a push never lands in the same cycle as a led read
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.issue))
    else $error("push and led issue in the same cycle");

  // write pointer stays inside the delay line
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp <= DEPTH_M1)
    else $error("delay line pointer out of range");

  // the last pipeline stage reaches the result register when it moves
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    v5 && advance |=> out_valid)
    else $error("result lost at the output register");

endmodule

>>> dv/sound_wave_ring_renderer_tb.sv
// ----------------------------------------------------------------------------
// sound_wave_ring_renderer_tb: self-checking bench for the ring renderer
// Pushes amplitude samples and render requests through the input channel and
// compares every led transfer against a local predictor of the delay line,
// ear geometry, gain scaling, saturation and brightness curve. A short
// directed script runs first, then randomized phases at several gain settings
// with bursty input traffic and patterned output stalls.
// ----------------------------------------------------------------------------
module sound_wave_ring_renderer_tb;
  import swrr_pkg::*;

  localparam int DRAIN_CYCLES    = 30;
  localparam int IDLE_LIMIT      = 1000;
  localparam int SPARE_REG_INDEX = 1;
  localparam int RANDOM_PHASES   = 6;
  localparam int PHASE_ITEMS     = 65;

  // knees of the brightness curve
  localparam int LEVEL_KNEES [17] = '{
    0, 3, 7, 12, 18, 25, 33, 43, 55, 69, 85, 103, 123, 145, 189, 217, 255
  };

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [LVL_W-1:0] level;
    logic             last;
  } led_value_t;

  typedef enum {
    ROW_PUSH,
    ROW_RENDER,
    ROW_RENDER_DARK,
    ROW_GAIN,
    ROW_SPARE_REG
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    int        value;
  } row_t;

  typedef enum {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               operation = OP_PUSH;
  logic [AMP_W-1:0]   amplitude = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [IDX_W-1:0]   led_index;
  logic [LVL_W-1:0]   brightness;
  logic               last;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // predictor state
  logic [AMP_W-1:0] delay_line [HIST_DEPTH];
  int               gain_setting = 0;
  led_value_t       leds_due [$];

  int fail_count    = 0;
  int frames_sent   = 0;
  int samples_sent  = 0;
  int leds_checked  = 0;
  int gain_writes   = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;

  row_t directed_rows [24] = '{
    '{ROW_RENDER_DARK, 0},
    '{ROW_GAIN, 0},
    '{ROW_PUSH, 255},
    '{ROW_PUSH, 255},
    '{ROW_RENDER_DARK, 0},
    '{ROW_GAIN, 255},
    '{ROW_RENDER, 0},
    '{ROW_PUSH, 255},
    '{ROW_PUSH, 255},
    '{ROW_PUSH, 255},
    '{ROW_PUSH, 255},
    '{ROW_PUSH, 255},
    '{ROW_PUSH, 255},
    '{ROW_PUSH, 255},
    '{ROW_PUSH, 255},
    '{ROW_RENDER, 0},
    '{ROW_SPARE_REG, 0},
    '{ROW_RENDER, 0},
    '{ROW_PUSH, 0},
    '{ROW_PUSH, 255},
    '{ROW_PUSH, 0},
    '{ROW_RENDER, 0},
    '{ROW_GAIN, 1},
    '{ROW_RENDER, 0}
  };

  sound_wave_ring_renderer uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .amplitude  (amplitude),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .led_index  (led_index),
    .brightness (brightness),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (delay_line[k]) delay_line[k] = '0;
  end

  // angle folded into 0..359
  function automatic int fold_angle(int a);
    int r;
    r = a % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    return r;
  endfunction

  // shortest arc from a to b, with the direction of the turn
  function automatic int arc_to(int a, int b, output bit ccw);
    int x;
    int y;
    int d;
    x = fold_angle(a);
    y = fold_angle(b);
    if (y >= x) begin
      d = y - x;
      ccw = 1'b1;
      if (d >= HALF_TURN) begin
        d = FULL_TURN - d;
        ccw = 1'b0;
      end
    end else begin
      d = x - y;
      ccw = 1'b0;
      if (d >= HALF_TURN) begin
        d = FULL_TURN - d;
        ccw = 1'b1;
      end
    end
    return d;
  endfunction

  function automatic int tap_value(int k);
    if (k < 0 || k >= HIST_DEPTH) return 0;
    return int'(delay_line[k]);
  endfunction

  // linear interpolation of the delay line at an angular span
  function automatic int wave_at(int span);
    int lo;
    int dx;
    int dy;
    if (span < 0 || span > HALF_TURN) return 0;
    lo = span / DEGREES_PER_TAP;
    dx = span - lo * DEGREES_PER_TAP;
    dy = tap_value(lo + 1) - tap_value(lo);
    return (tap_value(lo) + (dy * dx) / DEGREES_PER_TAP) & 255;
  endfunction

  // gain scaling with falloff over distance
  function automatic int ear_level(int span);
    int v;
    v = (wave_at(span) * gain_setting) >> 4;
    return (v * (HALF_TURN - span)) >> 7;
  endfunction

  function automatic logic [LVL_W-1:0] curve_level(int v);
    int p;
    int x;
    p = (v >> 4) & 15;
    x = v & 15;
    return LVL_W'(LEVEL_KNEES[p] + ((x * (LEVEL_KNEES[p + 1] - LEVEL_KNEES[p])) >> 4));
  endfunction

  // expected led values of one frame
  function automatic void predict_frame();
    led_value_t lv;
    int         deg;
    int         d1;
    int         d2;
    int         v;
    bit         t1;
    bit         t2;
    for (int i = 0; i < EMIT_COUNT; i++) begin
      deg = (i * FULL_TURN) / LED_COUNT - LED_ZERO_OFFSET;
      d1 = arc_to(deg, EAR_RIGHT, t1);
      d2 = arc_to(deg, EAR_LEFT, t2);
      v = 0;
      if (d1 <= EAR_REACH && !t1) v = ear_level(d1);
      // left ear overrides the right one
      if (d2 <= EAR_REACH && t2) v = ear_level(d2);
      if (v > 255) v = 255;
      lv.idx = IDX_W'(i);
      lv.level = curve_level(v);
      lv.last = (i == EMIT_COUNT - 1);
      leds_due.push_back(lv);
    end
  endfunction

  function automatic void shift_sample(logic [AMP_W-1:0] amp);
    for (int k = HIST_DEPTH - 1; k > 0; k--) delay_line[k] = delay_line[k - 1];
    delay_line[0] = amp;
  endfunction

  // one input transfer, preceded by a random gap at the start of each burst
  task automatic send_item(logic op, logic [AMP_W-1:0] amp, bit dark);
    int         gap;
    led_value_t lv;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        operation <= 1'($urandom);
        amplitude <= AMP_W'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    operation <= op;
    amplitude <= amp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_PUSH) begin
      shift_sample(amp);
      samples_sent++;
    end else begin
      frames_sent++;
      if (dark) begin
        // gain zero or empty delay line: every led stays off
        for (int i = 0; i < EMIT_COUNT; i++) begin
          lv.idx = IDX_W'(i);
          lv.level = '0;
          lv.last = (i == EMIT_COUNT - 1);
          leds_due.push_back(lv);
        end
      end else begin
        predict_frame();
      end
    end
  endtask

  // bring the block to rest before touching registers or ending
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (leds_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // register write followed by a read-back of the gain
  task automatic write_reg(int index, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    settle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(index * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (index == int'(REG_WAVE_GAIN)) begin
      gain_setting = int'(value[GAIN_W-1:0]);
      gain_writes++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    paddr <= PADDR_W'(int'(REG_WAVE_GAIN) * 4);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (rd !== PDATA_W'(gain_setting)) begin
      $error("wave_gain: expected %0d, got %0d", gain_setting, rd);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver stall pattern, switching style every so often
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_tick = 0;

  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 97 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 6);
      STALL_PERIODIC: out_stall <= (stall_tick % 3 == 0);
      default:        out_stall <= 1'b0;
    endcase
  end

  // compare each led transfer with the oldest expectation
  always @(posedge clk) begin
    led_value_t lv;
    if (!rst && out_valid && !out_stall) begin
      if (leds_due.size() == 0) begin
        $error("unexpected led transfer: led_index %0d brightness %0d last %0d",
               led_index, brightness, last);
        fail_count++;
      end else begin
        lv = leds_due.pop_front();
        leds_checked++;
        if (led_index !== lv.idx) begin
          $error("led_index: expected %0d, got %0d", lv.idx, led_index);
          fail_count++;
        end
        if (brightness !== lv.level) begin
          $error("brightness: expected %0d, got %0d", lv.level, brightness);
          fail_count++;
        end
        if (last !== lv.last) begin
          $error("last: expected %0d, got %0d", lv.last, last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int               phase_gain [RANDOM_PHASES];
    int               walk;
    logic [AMP_W-1:0] amp;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed script
    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_PUSH:        send_item(OP_PUSH, AMP_W'(directed_rows[r].value), 1'b0);
        ROW_RENDER:      send_item(OP_RENDER, AMP_W'($urandom), 1'b0);
        ROW_RENDER_DARK: send_item(OP_RENDER, AMP_W'($urandom), 1'b1);
        ROW_GAIN:        write_reg(int'(REG_WAVE_GAIN), PDATA_W'(directed_rows[r].value));
        ROW_SPARE_REG:   write_reg(SPARE_REG_INDEX, PDATA_W'(directed_rows[r].value));
        default: ;
      endcase
    end

    // random phases, each at its own gain and one of four sample styles
    phase_gain = '{255, 0, 1, 128, 0, 16};
    phase_gain[1] = $urandom_range(2, 254);
    phase_gain[4] = $urandom_range(0, 255);
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(int'(REG_WAVE_GAIN), PDATA_W'(phase_gain[ph]));
      if (ph == 3) write_reg(SPARE_REG_INDEX, $urandom);
      walk = $urandom_range(0, 255);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(OP_RENDER, AMP_W'($urandom), 1'b0);
        end else begin
          case (ph % 4)
            0: amp = AMP_W'($urandom);
            1: amp = ($urandom_range(0, 1) == 0) ? '0 : '1;
            2: amp = AMP_W'($urandom_range(0, 15));
            default: begin
              walk = walk + int'($urandom_range(0, 40)) - 20;
              if (walk < 0) walk = 0;
              if (walk > 255) walk = 255;
              amp = AMP_W'(walk);
            end
          endcase
          send_item(OP_PUSH, amp, 1'b0);
        end
      end
    end

    settle();
    $display("covered %0d frames and %0d samples, %0d led values compared",
             frames_sent, samples_sent, leds_checked);
    $display("gain written %0d times, zero and full scale included", gain_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
